[src/mmp_pkg.sv]
// Shared types and constants of the message mailbox pool.
`default_nettype none

package mmp_pkg;

  // Pool geometry
  localparam int SLOTS     = 32;
  localparam int MSG_BYTES = 64;
  localparam int TASKS     = 8;

  // Derived widths
  localparam int SlotW    = $clog2(SLOTS);
  localparam int ByteIdxW = $clog2(MSG_BYTES);
  localparam int LenW     = $clog2(MSG_BYTES);
  localparam int CountW   = $clog2(MSG_BYTES + 2);
  localparam int MemDepth = SLOTS << ByteIdxW;
  localparam int MemAddrW = SlotW + ByteIdxW;

  // Fixed field widths
  localparam int TaskW  = 3;
  localparam int ByteW  = 8;
  localparam int SizeW  = 7;
  localparam int OutLenW = 6;

  // Stream widths
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 24;

  // Command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_RECV
  } back_state_e;

  // Classified command, front to back
  typedef struct packed {
    op_e              op;
    logic [TaskW-1:0] task_id;
    logic [TaskW-1:0] peer;
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic             size_zero;
    logic [LenW-1:0]  lim;       // saturated buffer size minus one
  } cmd_t;

  // One result item
  typedef struct packed {
    op_e                kind;
    status_e            status;
    logic [TaskW-1:0]   sender;
    logic [ByteW-1:0]   out_byte;
    logic [OutLenW-1:0] length;
    logic               final_res;
  } res_t;

endpackage

`default_nettype wire

[src/message_mailbox_pool.sv]
// Top level of the message mailbox pool: front end, command queue, back end.
//
//  channel  dir  tdata (low bit up)                               tuser   tlast
//  s_axis   in   task_id[2:0] peer[5:3] data_byte[13:6]           action  last
//                buf_size[20:14], zeros above
//  m_axis   out  status[1:0] sender[4:2] out_byte[12:5]           kind    final_res
//                length[18:13], zeros above
//
// Send bytes stream at one per cycle; only the last byte of a run waits for
// a free output register. A receive first looks up a waiting slot; when it
// delivers any bytes, it reads them from the byte store and passes them on
// one by one, then a terminator, paced by the single read port of the byte
// store and by m_axis_tready. The back end works on one command at a time.
// Reset clears the slot used marks and the open send run; slot contents are
// left as they are and are only read after being written.
// The front keeps taking items into a four-entry queue while the back end
// waits on a stalled output; s_axis_tready drops only when the queue is full.
`default_nettype none

module message_mailbox_pool (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [mmp_pkg::InTdataW-1:0]  s_axis_tdata,  // task_id, peer, data_byte, buf_size
  input  wire logic                          s_axis_tuser,  // action
  input  wire logic                          s_axis_tlast,  // last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [mmp_pkg::OutTdataW-1:0]      m_axis_tdata,  // status, sender, out_byte, length
  output logic                               m_axis_tuser,  // kind
  output logic                               m_axis_tlast   // final_res
);

  logic           q_push, q_full, q_pop, q_valid;
  mmp_pkg::cmd_t  push_cmd, pop_cmd;
  mmp_pkg::res_t  res;

  mmp_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  mmp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  mmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // pack the result item onto the stream
  assign m_axis_tdata = {5'd0, res.length, res.out_byte, res.sender, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.final_res;

endmodule

`default_nettype wire

[src/mmp_front.sv]
// Front end: unpacks input items and classifies them into commands.
`default_nettype none

module mmp_front (
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [mmp_pkg::InTdataW-1:0]  s_data_i,
  input  wire logic                          s_user_i,
  input  wire logic                          s_last_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output mmp_pkg::cmd_t                      q_cmd_o
);

  logic [mmp_pkg::SizeW-1:0] buf_size;
  logic [mmp_pkg::SizeW-1:0] size_sat;
  logic [mmp_pkg::SizeW-1:0] size_m1;

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  always_comb begin
    buf_size = s_data_i[20:14];
    // clamp to the slot size
    if (32'(buf_size) > mmp_pkg::MSG_BYTES) begin
      size_sat = mmp_pkg::SizeW'(mmp_pkg::MSG_BYTES);
    end else begin
      size_sat = buf_size;
    end
    size_m1 = size_sat - mmp_pkg::SizeW'(1);

    q_cmd_o.op        = s_user_i ? mmp_pkg::OP_RECV : mmp_pkg::OP_SEND;
    q_cmd_o.task_id   = s_data_i[2:0];
    q_cmd_o.peer      = s_data_i[5:3];
    q_cmd_o.data_byte = s_data_i[13:6];
    q_cmd_o.last      = s_last_i;
    q_cmd_o.size_zero = (size_sat == '0);
    q_cmd_o.lim       = size_m1[mmp_pkg::LenW-1:0];
  end

endmodule

`default_nettype wire

[src/mmp_queue.sv]
// Short command queue between front and back.
`default_nettype none

module mmp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mmp_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mmp_pkg::cmd_t      pop_cmd_o
);

  mmp_pkg::cmd_t               entry_q [mmp_pkg::QDepth];
  logic [mmp_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mmp_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mmp_pkg::QPtrW:0]     cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o    = (cnt_q == (mmp_pkg::QPtrW+1)'(mmp_pkg::QDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[src/mmp_back.sv]
// Back end: slot pool, byte store, send run tracking and receive sequencer.
`default_nettype none

module mmp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire mmp_pkg::cmd_t q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mmp_pkg::res_t      out_res_o
);

  localparam int SlotW = mmp_pkg::SlotW;
  localparam int LenW  = mmp_pkg::LenW;

  mmp_pkg::back_state_e state_q, state_d;

  // slot metadata
  logic [mmp_pkg::SLOTS-1:0]      used_q, used_d;
  logic [mmp_pkg::TaskW-1:0]      rcv_q  [mmp_pkg::SLOTS];
  logic [mmp_pkg::TaskW-1:0]      snd_q  [mmp_pkg::SLOTS];
  logic [LenW-1:0]                slen_q [mmp_pkg::SLOTS];
  logic                           meta_we;
  logic [SlotW-1:0]               meta_idx;
  logic [mmp_pkg::TaskW-1:0]      meta_rcv, meta_snd;
  logic [LenW-1:0]                meta_len;

  // byte store
  logic [mmp_pkg::ByteW-1:0]      mem [mmp_pkg::MemDepth];
  logic                           mem_we, mem_re;
  logic [mmp_pkg::MemAddrW-1:0]   mem_waddr, mem_raddr;
  logic [mmp_pkg::ByteW-1:0]      mem_wdata, mem_rdata_q;

  // open send run
  logic                           open_q, open_d;
  logic [SlotW-1:0]               sslot_q, sslot_d;
  logic [mmp_pkg::CountW-1:0]     scnt_q, scnt_d;
  logic                           nslot_q, nslot_d;
  logic [mmp_pkg::TaskW-1:0]      stask_q, stask_d;
  logic [mmp_pkg::TaskW-1:0]      speer_q, speer_d;

  // receive run
  logic [SlotW-1:0]               rslot_q, rslot_d;
  logic [mmp_pkg::TaskW-1:0]      rsnd_q, rsnd_d;
  logic [LenW-1:0]                rlen_q, rlen_d;
  logic [LenW-1:0]                ridx_q, ridx_d;
  logic                           rpend_q, rpend_d;

  logic                           out_valid_q, out_valid_d;
  mmp_pkg::res_t                  out_q, out_d;

  // combinational helpers
  logic                           out_load;
  logic                           free_any, match_any;
  logic [SlotW-1:0]               free_idx, match_idx;
  logic [SlotW-1:0]               eff_slot;
  logic [mmp_pkg::CountW-1:0]     eff_cnt, cnt_new;
  logic                           eff_nslot;
  logic [mmp_pkg::TaskW-1:0]      eff_task, eff_peer;
  logic [LenW-1:0]                stored_len;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_load    = !out_valid_q || out_ready_i;

  // lowest free slot and lowest slot waiting for the requesting task
  always_comb begin
    free_any  = 1'b0;
    free_idx  = '0;
    match_any = 1'b0;
    match_idx = '0;
    for (int i = mmp_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
      if (used_q[i] && (rcv_q[i] == q_cmd_i.task_id)) begin
        match_any = 1'b1;
        match_idx = SlotW'(i);
      end
    end
  end

  // send run values as seen by this byte
  always_comb begin
    if (open_q) begin
      eff_slot  = sslot_q;
      eff_cnt   = scnt_q;
      eff_nslot = nslot_q;
      eff_task  = stask_q;
      eff_peer  = speer_q;
    end else begin
      eff_slot  = free_idx;
      eff_cnt   = '0;
      eff_nslot = !free_any;
      eff_task  = q_cmd_i.task_id;
      eff_peer  = q_cmd_i.peer;
    end
    if (32'(eff_cnt) <= mmp_pkg::MSG_BYTES) begin
      cnt_new = eff_cnt + 1'b1;
    end else begin
      cnt_new = eff_cnt;
    end
    if (32'(cnt_new) < mmp_pkg::MSG_BYTES) begin
      stored_len = cnt_new[LenW-1:0];
    end else begin
      stored_len = LenW'(mmp_pkg::MSG_BYTES - 1);
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    open_d      = open_q;
    sslot_d     = sslot_q;
    scnt_d      = scnt_q;
    nslot_d     = nslot_q;
    stask_d     = stask_q;
    speer_d     = speer_q;
    rslot_d     = rslot_q;
    rsnd_d      = rsnd_q;
    rlen_d      = rlen_q;
    ridx_d      = ridx_q;
    rpend_d     = rpend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {eff_slot, eff_cnt[mmp_pkg::ByteIdxW-1:0]};
    mem_wdata   = q_cmd_i.data_byte;
    mem_re      = 1'b0;
    mem_raddr   = {rslot_q, ridx_q[mmp_pkg::ByteIdxW-1:0]};
    meta_we     = 1'b0;
    meta_idx    = eff_slot;
    meta_rcv    = eff_peer;
    meta_snd    = eff_task;
    meta_len    = stored_len;

    unique case (state_q)
      mmp_pkg::BK_IDLE: begin
        if (q_valid_i && (q_cmd_i.op == mmp_pkg::OP_SEND)) begin
          if (!q_cmd_i.last || out_load) begin
            q_pop_o = 1'b1;
            mem_we  = !eff_nslot && (32'(eff_cnt) < mmp_pkg::MSG_BYTES - 1);
            sslot_d = eff_slot;
            scnt_d  = cnt_new;
            nslot_d = eff_nslot;
            stask_d = eff_task;
            speer_d = eff_peer;
            open_d  = !q_cmd_i.last;
            if (q_cmd_i.last) begin
              out_valid_d      = 1'b1;
              out_d            = '0;
              out_d.kind       = mmp_pkg::OP_SEND;
              out_d.final_res  = 1'b1;
              if ((32'(cnt_new) > mmp_pkg::MSG_BYTES) ||
                  (32'(eff_peer) >= mmp_pkg::TASKS)) begin
                out_d.status = mmp_pkg::ST_BAD;
              end else if (eff_nslot) begin
                out_d.status = mmp_pkg::ST_NONE;
              end else begin
                out_d.status     = mmp_pkg::ST_OK;
                meta_we          = 1'b1;
                used_d[eff_slot] = 1'b1;
              end
            end
          end
        end else if (q_valid_i && out_load) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.size_zero || !match_any) begin
            out_valid_d     = 1'b1;
            out_d           = '0;
            out_d.kind      = mmp_pkg::OP_RECV;
            out_d.final_res = 1'b1;
            out_d.status    = q_cmd_i.size_zero ? mmp_pkg::ST_BAD : mmp_pkg::ST_NONE;
          end else begin
            used_d[match_idx] = 1'b0;
            rslot_d = match_idx;
            rsnd_d  = snd_q[match_idx];
            rlen_d  = (slen_q[match_idx] > q_cmd_i.lim) ? q_cmd_i.lim : slen_q[match_idx];
            ridx_d  = '0;
            rpend_d = 1'b0;
            state_d = mmp_pkg::BK_RECV;
          end
        end
      end
      mmp_pkg::BK_RECV: begin
        // a fetched byte moves on once the output register frees
        if (rpend_q && out_load) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mmp_pkg::OP_RECV;
          out_d.status    = mmp_pkg::ST_OK;
          out_d.sender    = rsnd_q;
          out_d.out_byte  = mem_rdata_q;
          out_d.length    = mmp_pkg::OutLenW'(rlen_q);
          out_d.final_res = 1'b0;
          rpend_d         = 1'b0;
        end
        if ((ridx_q != rlen_q) && (!rpend_q || out_load)) begin
          mem_re  = 1'b1;
          ridx_d  = ridx_q + 1'b1;
          rpend_d = 1'b1;
        end
        if ((ridx_q == rlen_q) && !rpend_q && out_load) begin
          out_valid_d     = 1'b1;
          out_d.kind      = mmp_pkg::OP_RECV;
          out_d.status    = mmp_pkg::ST_OK;
          out_d.sender    = rsnd_q;
          out_d.out_byte  = '0;
          out_d.length    = mmp_pkg::OutLenW'(rlen_q);
          out_d.final_res = 1'b1;
          state_d         = mmp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = mmp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmp_pkg::BK_IDLE;
      used_q      <= '0;
      open_q      <= 1'b0;
      sslot_q     <= '0;
      scnt_q      <= '0;
      nslot_q     <= 1'b0;
      rpend_q     <= 1'b0;
      ridx_q      <= '0;
      rlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      open_q      <= open_d;
      sslot_q     <= sslot_d;
      scnt_q      <= scnt_d;
      nslot_q     <= nslot_d;
      rpend_q     <= rpend_d;
      ridx_q      <= ridx_d;
      rlen_q      <= rlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stask_q <= stask_d;
    speer_q <= speer_d;
    rslot_q <= rslot_d;
    rsnd_q  <= rsnd_d;
    out_q   <= out_d;
    if (meta_we) begin
      rcv_q[meta_idx]  <= meta_rcv;
      snd_q[meta_idx]  <= meta_snd;
      slen_q[meta_idx] <= meta_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire
